// ===== hdl/bcdc_pkg.sv =====
// Package for the binary to packed BCD unit: widths, the beat type that walks
// the cell chain, and the digit-adjust function used by every cell.
// No dependencies.
`default_nettype none

package bcdc_pkg;

    localparam int VALUE_W       = 64;
    localparam int NUM_BITS      = VALUE_W - 1;
    localparam int NUM_DIGITS    = 19;
    localparam int BCD_W         = 4 * NUM_DIGITS;
    localparam int OUT_W         = 64;
    localparam int CFG_W         = 4;
    localparam int MAX_BCD_BYTES = 8;
    localparam logic [CFG_W-1:0] BCD_BYTES_RESET = CFG_W'(8);

    typedef struct packed {
        logic                valid;
        logic                neg;
        logic [NUM_BITS-1:0] bin;
        logic [BCD_W-1:0]    bcd;
    } bcdc_beat_t;

    // add three to every digit of five or more before the next shift
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (b[4*d +: 4] >= 4'd5) begin
                r[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bcdc_cell.sv =====
// One cell of the shift-and-add-3 chain: adjusts the BCD digits, shifts in
// the next binary bit and hands the beat to its neighbor. Uses bcdc_pkg.
`default_nettype none

module bcdc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  bcdc_pkg::bcdc_beat_t beat_in,
    output bcdc_pkg::bcdc_beat_t beat_out
);
    import bcdc_pkg::*;

    bcdc_beat_t       beat_reg;
    bcdc_beat_t       beat_next;
    logic [BCD_W-1:0] adj;

    always_comb begin
        adj             = dabble(beat_in.bcd);
        beat_next.valid = beat_in.valid;
        beat_next.neg   = beat_in.neg;
        beat_next.bin   = {beat_in.bin[NUM_BITS-2:0], 1'b0};
        beat_next.bcd   = {adj[BCD_W-2:0], beat_in.bin[NUM_BITS-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (adv) begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire

// ===== hdl/bcdc_out.sv =====
// Output stage: range check against the configured byte count, zeroing on
// failure, and the output register that parts the chain from the receiver.
// Uses bcdc_pkg.
`default_nettype none

module bcdc_out #(
    parameter int MAX_BCD_BYTES = bcdc_pkg::MAX_BCD_BYTES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bcdc_pkg::bcdc_beat_t        beat_in,
    input  logic [bcdc_pkg::CFG_W-1:0] bcd_bytes,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [bcdc_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tuser,
    output logic                       adv
);
    import bcdc_pkg::*;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic             m_ok_reg;
    logic             load;
    logic [CFG_W-1:0] nbytes;
    logic [BCD_W-1:0] hi_mask;
    logic             good;

    always_comb begin
        nbytes = (bcd_bytes > CFG_W'(MAX_BCD_BYTES)) ? CFG_W'(MAX_BCD_BYTES) : bcd_bytes;
        for (int j = 0; j < BCD_W; j++) begin
            hi_mask[j] = (j >= 8 * int'(nbytes));
        end
        good = !beat_in.neg && ((beat_in.bcd & hi_mask) == '0);
    end

    assign load = !m_valid_reg || m_tready;
    assign adv  = load || !beat_in.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= beat_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= good ? beat_in.bcd[OUT_W-1:0] : '0;
            m_ok_reg   <= good;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ok_reg;

endmodule

`default_nettype wire

// ===== hdl/binary_to_packed_bcd_unit.sv =====
// Binary to packed BCD unit: a chain of shift-and-add-3 cells, one per value
// bit below the sign bit, followed by the output stage. Uses bcdc_pkg, bcdc_cell, bcdc_out.
//
// Usage:
//   s_ channel: one beat carries a signed 64-bit value in s_tdata.
//   m_ channel: one beat per input beat, in order; m_tdata holds the packed
//   BCD digits right-aligned, m_tuser is ok. A negative value or one with
//   more digits than the configured byte count gives m_tdata zero, ok low.
//   cfg channel: cfg_data sets the byte count (values above the maximum
//   saturate); cfg_ready is always high. Write it only while the unit is idle.
//   Path: a result passes through each cell of the 63-cell chain and then
//   the output register.
//   Throughput: one beat per cycle, new beats enter every cycle while s_tready is high.
//   Reset: empties the chain and the output register, byte count goes to 8.
//   Stall: while m_tready is low the result holds; the chain keeps advancing
//   until a valid beat reaches its last cell, then s_tready drops.
`default_nettype none

module binary_to_packed_bcd_unit #(
    parameter int MAX_BCD_BYTES = bcdc_pkg::MAX_BCD_BYTES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bcdc_pkg::VALUE_W-1:0] s_tdata,   // [63:0] value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bcdc_pkg::OUT_W-1:0]   m_tdata,   // [63:0] bcd_value
    output logic                         m_tuser,   // [0] ok
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bcdc_pkg::CFG_W-1:0]   cfg_data   // [3:0] bcd_bytes
);
    import bcdc_pkg::*;

    logic             adv;
    logic [CFG_W-1:0] bcd_bytes_reg;
    bcdc_beat_t       stage [0:NUM_BITS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcd_bytes_reg <= BCD_BYTES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bcd_bytes_reg <= cfg_data;
        end
    end

    assign s_tready = adv;

    always_comb begin
        stage[0].valid = s_tvalid;
        stage[0].neg   = s_tdata[VALUE_W-1];
        stage[0].bin   = s_tdata[NUM_BITS-1:0];
        stage[0].bcd   = '0;
    end

    for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
        bcdc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .beat_in  (stage[i]),
            .beat_out (stage[i+1])
        );
    end

    bcdc_out #(
        .MAX_BCD_BYTES (MAX_BCD_BYTES)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_in   (stage[NUM_BITS]),
        .bcd_bytes (bcd_bytes_reg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .adv       (adv)
    );

endmodule

`default_nettype wire

// ===== hdl/bcdc_checker.sv =====
// Port-level checks for binary_to_packed_bcd_unit, attached by bind.
// Uses bcdc_pkg.
`default_nettype none

module bcdc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bcdc_pkg::OUT_W-1:0]   m_tdata,
    input logic                         m_tuser
);
    import bcdc_pkg::*;

    function automatic logic all_digits(input logic [OUT_W-1:0] d);
        logic r;
        r = 1'b1;
        for (int k = 0; k < OUT_W / 4; k++) begin
            if (d[4*k +: 4] > 4'd9) begin
                r = 1'b0;
            end
        end
        return r;
    endfunction

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed conversion with nonzero digits");

    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> all_digits(m_tdata))
        else $error("digit above nine in result");

endmodule

bind binary_to_packed_bcd_unit bcdc_checker u_bcdc_checker (.*);

`default_nettype wire

// ===== tb/binary_to_packed_bcd_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench for binary_to_packed_bcd_unit: directed table, then random values over
// several byte counts and handshake pressures, checked against an in-bench predictor.
// Depends on bcdc_pkg and the binary_to_packed_bcd_unit RTL.

module binary_to_packed_bcd_unit_test;
    import bcdc_pkg::*;

    localparam int LATENCY     = 63;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 13;
    localparam int PHASE_BEATS = 72;

    typedef struct packed {
        logic [OUT_W-1:0] bcd;
        logic             ok;
    } bcd_result_t;

    typedef struct packed {
        logic [CFG_W-1:0]   nbytes;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [OUT_W-1:0]   bcd;
        logic               ok;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{4'd8,  64'd0,                      1'b1, 64'h0,                 1'b1},
        '{4'd8,  64'd1,                      1'b1, 64'h1,                 1'b1},
        '{4'd8,  64'd12345678,               1'b1, 64'h12345678,          1'b1},
        '{4'd8,  64'd1234567890123456,       1'b1, 64'h1234567890123456,  1'b1},
        '{4'd8,  64'd9999999999999999,       1'b1, 64'h9999999999999999,  1'b1},
        '{4'd8,  64'd10000000000000000,      1'b1, 64'h0,                 1'b0},
        '{4'd8,  64'h7FFF_FFFF_FFFF_FFFF,    1'b1, 64'h0,                 1'b0},
        '{4'd8,  64'hFFFF_FFFF_FFFF_FFFF,    1'b1, 64'h0,                 1'b0},
        '{4'd8,  64'h8000_0000_0000_0000,    1'b1, 64'h0,                 1'b0},
        '{4'd8,  64'd9081726354,             1'b0, 64'h0,                 1'b0},
        '{4'd1,  64'd99,                     1'b1, 64'h99,                1'b1},
        '{4'd1,  64'd100,                    1'b1, 64'h0,                 1'b0},
        '{4'd1,  64'd0,                      1'b1, 64'h0,                 1'b1},
        '{4'd1,  64'hFFFF_FFFF_FFFF_FFFF,    1'b1, 64'h0,                 1'b0},
        '{4'd0,  64'd0,                      1'b1, 64'h0,                 1'b1},
        '{4'd0,  64'd1,                      1'b1, 64'h0,                 1'b0},
        '{4'd0,  64'hFFFF_FFFF_FFFF_FFFB,    1'b1, 64'h0,                 1'b0},
        '{4'd15, 64'd9999999999999999,       1'b1, 64'h9999999999999999,  1'b1},
        '{4'd15, 64'd10000000000000000,      1'b1, 64'h0,                 1'b0},
        '{4'd9,  64'd12345,                  1'b0, 64'h0,                 1'b0},
        '{4'd4,  64'd99999999,               1'b1, 64'h99999999,          1'b1},
        '{4'd4,  64'd100000000,              1'b1, 64'h0,                 1'b0},
        '{4'd4,  64'd31415926,               1'b1, 64'h31415926,          1'b1}
    };

    localparam logic [CFG_W-1:0] PHASE_BYTES [0:PHASES-1] = '{
        4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd9, 4'd2, 4'd7, 4'd4, 4'd6, 4'd12, 4'd8
    };
    localparam int SRC_IDLE_PCT [0:3] = '{0, 49, 0, 10};
    localparam int SNK_STALL_PCT [0:3] = '{0, 0, 49, 10};

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data  = '0;

    bcd_result_t        pending_results[$];
    logic [CFG_W-1:0]   byte_count = BCD_BYTES_RESET;
    int                 src_idle_pct;
    int                 snk_stall_pct;
    int                 mismatch_count;
    int                 cycle_count;

    binary_to_packed_bcd_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic bcd_result_t convert_to_bcd(input logic [VALUE_W-1:0] v,
                                                   input logic [CFG_W-1:0] nbytes);
        bcd_result_t        r;
        logic [VALUE_W-1:0] rest;
        int                 ndigits;
        rest    = v;
        r.bcd   = '0;
        ndigits = 2 * ((nbytes > MAX_BCD_BYTES) ? MAX_BCD_BYTES : int'(nbytes));
        if (v[VALUE_W-1]) begin
            r.ok = 1'b0;
            return r;
        end
        for (int k = 0; k < ndigits; k++) begin
            r.bcd[4*k +: 4] = 4'(rest % 10);
            rest = rest / 10;
        end
        r.ok = (rest == 0);
        if (!r.ok) begin
            r.bcd = '0;
        end
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] power_of_ten(input int n);
        logic [VALUE_W-1:0] p;
        p = 1;
        for (int k = 0; k < n; k++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // mostly values sized around the configured digit count, some negatives and raw noise
    function automatic logic [VALUE_W-1:0] pick_value(input logic [CFG_W-1:0] nbytes);
        int                 sel;
        int                 ndigits;
        logic [VALUE_W-1:0] raw;
        logic [VALUE_W-1:0] lim;
        sel     = $urandom_range(99);
        ndigits = 2 * ((nbytes > MAX_BCD_BYTES) ? MAX_BCD_BYTES : int'(nbytes));
        raw     = {$urandom, $urandom};
        lim     = power_of_ten(ndigits);
        if (sel < 10) begin
            return {1'b1, raw[VALUE_W-2:0]};
        end else if (sel < 20) begin
            return raw;
        end else if (sel < 35) begin
            if (raw[0] || ndigits == 0) begin
                return lim + VALUE_W'($urandom_range(3));
            end
            return lim - 1 - VALUE_W'($urandom_range(3));
        end
        return raw % power_of_ten($urandom_range(ndigits + 2));
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("ERROR %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v, input bcd_result_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(want);
    endtask

    task automatic set_byte_count(input logic [CFG_W-1:0] nbytes);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= nbytes;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        byte_count = nbytes;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin : check_results
        bcd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.bcd) begin
                    report_mismatch("bcd_value", m_tdata, want.bcd);
                end
                if (m_tuser !== want.ok) begin
                    report_mismatch("ok", OUT_W'(m_tuser), OUT_W'(want.ok));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].nbytes != byte_count) begin
                set_byte_count(DIRECTED[i].nbytes);
            end
            if (DIRECTED[i].typed) begin
                send_value(DIRECTED[i].value, '{DIRECTED[i].bcd, DIRECTED[i].ok});
            end else begin
                send_value(DIRECTED[i].value,
                           convert_to_bcd(DIRECTED[i].value, byte_count));
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            set_byte_count(PHASE_BYTES[p]);
            src_idle_pct  = SRC_IDLE_PCT[p % 4];
            snk_stall_pct = SNK_STALL_PCT[p % 4];
            for (int n = 0; n < PHASE_BEATS; n++) begin
                logic [VALUE_W-1:0] v;
                v = pick_value(byte_count);
                send_value(v, convert_to_bcd(v, byte_count));
            end
        end

        s_tvalid <= 1'b0;
        snk_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
